FILE: design/csvt_pkg.sv
`timescale 1ns / 1ps

package csvt_pkg;

    localparam logic [7:0] QuoteChar    = 8'h22;
    localparam logic [7:0] CrChar       = 8'h0D;
    localparam logic [7:0] LfChar       = 8'h0A;
    localparam logic [7:0] DefaultDelim = 8'h2C;

    // Most results that one input byte can cause.
    localparam int MaxResults = 3;
    localparam int CountWidth = $clog2(MaxResults + 1);
    localparam int IndexWidth = $clog2(MaxResults);

    localparam int QueueDepth = 4;

    typedef enum logic
    {
        KIND_BYTE      = 1'b0,
        KIND_FIELD_END = 1'b1
    } item_kind_t;

    typedef struct packed
    {
        item_kind_t kind;
        logic [7:0] field_byte;
        logic       row_end;
    } result_t;

    // All results of one input byte, packed in order from slot 0 up.
    typedef struct packed
    {
        result_t [MaxResults-1:0] slots;
        logic [CountWidth-1:0]    count;
        logic                     is_header;
    } bundle_t;

    localparam int BundleWidth = $bits(bundle_t);

endpackage

FILE: design/csvt_front.sv
`timescale 1ns / 1ps

module csvt_front
    import csvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] delimiter,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tlast,   // stream_end
    input  logic       queue_full,
    output logic       push,
    output bundle_t    push_bundle
);

    logic quoted_reg, quoted_next;
    logic qpend_reg, qpend_next;
    logic crpend_reg, crpend_next;
    logic nonempty_reg, nonempty_next;
    logic hdr_seen_reg, hdr_seen_next;

    logic       accept;
    logic [7:0] b;
    logic       done;
    logic       quoted_a;
    logic       not_lf;
    logic       a_valid, b_valid, c_valid;
    logic       b_line;
    logic       ne_end;
    logic       line_done;
    result_t    res_a, res_b, res_c;

    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    always_comb
    begin
        // A quote waiting inside quotes is resolved by this byte first.
        done     = qpend_reg && (b == QuoteChar);
        quoted_a = (qpend_reg && (b != QuoteChar)) ? 1'b0 : quoted_reg;
        not_lf   = !done && (b != LfChar);

        // Held carriage return that turns out to belong to the line.
        a_valid = not_lf && crpend_reg;
        res_a.kind       = ((CrChar == delimiter) && !quoted_a) ? KIND_FIELD_END : KIND_BYTE;
        res_a.field_byte = (res_a.kind == KIND_FIELD_END) ? 8'h00 : CrChar;
        res_a.row_end    = 1'b0;

        b_line  = not_lf && (b != CrChar);
        b_valid = done || (b_line && (b != QuoteChar));
        res_b.kind       = (!done && (b == delimiter) && !quoted_a) ? KIND_FIELD_END : KIND_BYTE;
        res_b.field_byte = (res_b.kind == KIND_FIELD_END) ? 8'h00 : b;
        res_b.row_end    = 1'b0;

        ne_end    = nonempty_reg || done || a_valid || b_line;
        line_done = (!done && (b == LfChar)) || (s_axis_tlast && (done || (b != LfChar)));
        c_valid   = line_done && ne_end;
        res_c.kind       = KIND_FIELD_END;
        res_c.field_byte = 8'h00;
        res_c.row_end    = 1'b1;

        push_bundle.slots[0]  = a_valid ? res_a : (b_valid ? res_b : res_c);
        push_bundle.slots[1]  = (a_valid && b_valid) ? res_b : res_c;
        push_bundle.slots[2]  = res_c;
        push_bundle.count     = CountWidth'(a_valid) + CountWidth'(b_valid)
                                + CountWidth'(c_valid);
        push_bundle.is_header = !hdr_seen_reg;

        push = accept && (push_bundle.count != '0);

        quoted_next   = (b_line && (b == QuoteChar) && !quoted_a) ? 1'b1 : quoted_a;
        qpend_next    = b_line && (b == QuoteChar) && quoted_a;
        crpend_next   = done ? crpend_reg : (not_lf && (b == CrChar));
        nonempty_next = ne_end;
        if (line_done)
        begin
            quoted_next   = 1'b0;
            qpend_next    = 1'b0;
            crpend_next   = 1'b0;
            nonempty_next = 1'b0;
        end
        hdr_seen_next = s_axis_tlast ? 1'b0 : (hdr_seen_reg || c_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg   <= 1'b0;
            qpend_reg    <= 1'b0;
            crpend_reg   <= 1'b0;
            nonempty_reg <= 1'b0;
            hdr_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            quoted_reg   <= quoted_next;
            qpend_reg    <= qpend_next;
            crpend_reg   <= crpend_next;
            nonempty_reg <= nonempty_next;
            hdr_seen_reg <= hdr_seen_next;
        end
    end

endmodule

FILE: design/csvt_queue.sv
`timescale 1ns / 1ps

module csvt_queue
    import csvt_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_bundle,
    input  logic    pop,
    output logic    full,
    output logic    nonempty,
    output bundle_t head
);

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

    bundle_t entries_reg [DEPTH];
    logic [PtrWidth-1:0] wptr_reg, wptr_next;
    logic [PtrWidth-1:0] rptr_reg, rptr_next;
    logic [CntWidth-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = (count_reg == CntWidth'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entries_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == LastPtr) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LastPtr) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wptr_reg] <= push_bundle;
        end
    end

endmodule

FILE: design/csvt_back.sv
`timescale 1ns / 1ps

module csvt_back
    import csvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_nonempty,
    input  bundle_t    queue_head,
    output logic       pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // field_byte
    output logic [2:0] m_axis_tuser,   // item_kind, row_end, is_header
    output logic       m_axis_tlast    // run_last
);

    bundle_t               cur_reg;
    logic                  have_reg, have_next;
    logic [IndexWidth-1:0] idx_reg, idx_next;
    logic                  last_slot;
    logic                  load;
    result_t               slot;

    assign slot      = cur_reg.slots[idx_reg];
    assign last_slot = (CountWidth'(idx_reg) + CountWidth'(1)) == cur_reg.count;

    assign m_axis_tvalid = have_reg;
    assign m_axis_tdata  = slot.field_byte;
    assign m_axis_tuser  = {cur_reg.is_header, slot.row_end, slot.kind};
    assign m_axis_tlast  = last_slot;

    always_comb
    begin
        have_next = have_reg;
        idx_next  = idx_reg;
        load      = 1'b0;
        if (!have_reg || (m_axis_tready && last_slot))
        begin
            // No bundle held, or the current bundle is done: take the next one from the queue.
            load      = queue_nonempty;
            have_next = queue_nonempty;
            idx_next  = '0;
        end
        else if (m_axis_tready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    assign pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            have_reg <= have_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= queue_head;
        end
    end

endmodule

FILE: design/csv_field_tokenizer_unit.sv
`timescale 1ns / 1ps

// CSV field tokenizer. Raw file bytes enter on the slave stream, one beat per
// byte, with tlast marking the final byte of a file; field content bytes and
// field-end marks leave on the master stream. The front end accepts one byte
// per clock whenever the result queue has room, so input bytes are taken at
// one per cycle until the queue fills. A byte causes zero to three results,
// and the output side sends one result per cycle while m_axis_tready is
// high, so a byte with several results (a flushed carriage return, the byte,
// a row end) holds the output until all are sent; the QUEUE_DEPTH-entry queue
// absorbs these bursts. Results pass through the queue and an output register.
// The delimiter (comma after reset) is written on the cfg channel and should
// only be changed while the block is idle.
module csv_field_tokenizer_unit
    import csvt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,        // delimiter_char
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // in_byte
    input  logic       s_axis_tlast,    // stream_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // field_byte
    output logic [2:0] m_axis_tuser,    // item_kind, row_end, is_header
    output logic       m_axis_tlast     // run_last
);

    logic [7:0] delim_reg;
    logic       push, pop, q_full, q_nonempty;
    bundle_t    push_bundle, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DefaultDelim;
        end
        else if (cfg_valid)
        begin
            delim_reg <= cfg_data;
        end
    end

    csvt_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .delimiter     (delim_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (q_full),
        .push          (push),
        .push_bundle   (push_bundle)
    );

    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .full        (q_full),
        .nonempty    (q_nonempty),
        .head        (q_head)
    );

    csvt_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_nonempty (q_nonempty),
        .queue_head     (q_head),
        .pop            (pop),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

endmodule
